@@ rtl/core/modular_inverse_by_euler_power_macros.svh @@
// Assertion macros shared by the modular inverse block.
// Included by modules that carry concurrent checks.
`ifndef MODULAR_INVERSE_BY_EULER_POWER_MACROS_SVH
`define MODULAR_INVERSE_BY_EULER_POWER_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define MIEP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication checked outside reset.
`define MIEP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

@@ rtl/core/miep_pkg.sv @@
// Package for the modular inverse block: widths, state codes, cell types.
// No dependencies.
package miep_pkg;
  localparam int WIDTH = 32;
  localparam int CW    = $clog2(WIDTH + 1);

  typedef logic [WIDTH-1:0] word_t;

  // Control state of the sequencer.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MUL,
    ST_SQR,
    ST_CHECK,
    ST_DONE
  } state_t;

  // Data handed along the row of cells each cycle.
  typedef struct packed {
    logic carry;
    logic borrow;
  } link_t;
endpackage

@@ rtl/core/miep_if.sv @@
// Valid/ready channel interfaces for requests and results.
// Depends on miep_pkg.
interface miep_in_if;
  logic                 valid;
  logic                 ready;
  miep_pkg::word_t      value;
  miep_pkg::word_t      modulus;
  miep_pkg::word_t      totient;
  modport source (output valid, value, modulus, totient, input ready);
  modport sink   (input valid, value, modulus, totient, output ready);
endinterface

interface miep_out_if;
  logic                 valid;
  logic                 ready;
  miep_pkg::word_t      power_result;
  logic                 invertible;
  modport source (output valid, power_result, invertible, input ready);
  modport sink   (input valid, power_result, invertible, output ready);
endinterface

@@ rtl/core/miep_cell.sv @@
// One bit slice of the modular accumulator: holds one accumulator bit,
// forms accumulator+addend sum and subtracts the modulus, ripple to neighbor.
// Depends on miep_pkg.
module miep_cell (
  input  logic               clk,
  input  logic               load,
  input  logic               acc_in,
  input  logic               add_bit,
  input  logic               mod_bit,
  input  logic               take_diff,
  input  miep_pkg::link_t    link_in,
  output miep_pkg::link_t    link_out,
  input  logic               new_bit,
  output logic               acc
);
  logic s;
  logic d;

  // Sum of incoming bit and addend, then difference against modulus
  assign s                = acc_in ^ add_bit ^ link_in.carry;
  assign link_out.carry   = (acc_in & add_bit) | (link_in.carry & (acc_in ^ add_bit));
  assign d                = s ^ mod_bit ^ link_in.borrow;
  assign link_out.borrow  = (~s & mod_bit) | (link_in.borrow & ~(s ^ mod_bit));

  // Accumulator bit register
  always_ff @(posedge clk) begin
    if (load) begin
      acc <= new_bit;
    end else begin
      acc <= take_diff ? d : s;
    end
  end
endmodule

@@ rtl/core/miep_mulmod.sv @@
// Bit-serial modular multiplier: a row of cells, one multiplier bit per
// step (double, then add), each step a doubling pass and an add pass.
// Depends on miep_pkg, miep_cell.
module miep_mulmod (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  miep_pkg::word_t  a,
  input  miep_pkg::word_t  b,
  input  miep_pkg::word_t  m,
  output logic             done,
  output miep_pkg::word_t  prod
);
  localparam int WIDTH = miep_pkg::WIDTH;

  logic                  busy;
  logic                  phase;
  logic [miep_pkg::CW-1:0] cnt;
  miep_pkg::word_t       mult;
  miep_pkg::word_t       acc;
  miep_pkg::word_t       addend;
  miep_pkg::link_t       links [WIDTH+1];
  logic                  take_diff;

  // Phase 0 doubles, phase 1 adds a when the current multiplier bit is set
  assign addend = phase ? (mult[WIDTH-1] ? a : '0) : acc;
  assign links[0] = '{carry: 1'b0, borrow: 1'b0};

  // Take the reduced value when the sum reached or passed the modulus
  assign take_diff = links[WIDTH].carry | ~links[WIDTH].borrow;

  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    miep_cell u_cell (
      .clk       (clk),
      .load      (start),
      .acc_in    (acc[i]),
      .add_bit   (addend[i]),
      .mod_bit   (m[i]),
      .take_diff (take_diff),
      .link_in   (links[i]),
      .link_out  (links[i+1]),
      .new_bit   (1'b0),
      .acc       (acc[i])
    );
  end

  assign prod = acc;

  // Step sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        cnt   <= '0;
      end else if (busy) begin
        phase <= ~phase;
        if (phase) begin
          if (cnt == miep_pkg::CW'(WIDTH - 1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mult <= b;
    end else if (busy && phase) begin
      mult <= {mult[WIDTH-2:0], 1'b0};
    end
  end
endmodule

@@ rtl/core/modular_inverse_by_euler_power.sv @@
// Top level: modular inverse as value^(totient-1) mod modulus with an
// invertibility check. Depends on miep_pkg, miep_if, miep_mulmod, macros.
//
//  channel | dir | fields
//  in      | in  | value, modulus, totient
//  out     | out | power_result, invertible
//
// One request at a time. Each modular product is formed in the cell row; a
// request costs up to WIDTH squarings, up to WIDTH multiplications and one
// check product, plus the value reduction. The shared multiplier sets the rate.
// rst is synchronous and clears control state. A stalled result holds.
`include "modular_inverse_by_euler_power_macros.svh"

module modular_inverse_by_euler_power (
  input  logic        clk,
  input  logic        rst,
  miep_in_if.sink     in_ch,
  miep_out_if.source  out_ch
);
  localparam int WIDTH = miep_pkg::WIDTH;

  miep_pkg::state_t state;
  miep_pkg::state_t state_next;

  miep_pkg::word_t  m;
  miep_pkg::word_t  base;
  miep_pkg::word_t  base0;
  miep_pkg::word_t  expo;
  miep_pkg::word_t  result;
  miep_pkg::word_t  rem_v;
  miep_pkg::word_t  quo;
  logic [WIDTH:0]   rem_try;
  logic [miep_pkg::CW-1:0] cnt;
  logic             mm_start;
  logic             mm_done;
  miep_pkg::word_t  mm_a;
  miep_pkg::word_t  mm_b;
  miep_pkg::word_t  mm_prod;
  logic             launched;
  logic             inv_flag;
  logic             out_valid;
  miep_pkg::word_t  out_power;
  logic             out_inv;

  assign in_ch.ready         = (state == miep_pkg::ST_IDLE);
  assign out_ch.valid        = out_valid;
  assign out_ch.power_result = out_power;
  assign out_ch.invertible   = out_inv;

  // Restoring division step for the value reduction
  assign rem_try = {rem_v, quo[WIDTH-1]} - {1'b0, m};

  // Shared multiplier operands
  always_comb begin
    case (state)
      miep_pkg::ST_MUL:   begin mm_a = result; mm_b = base; end
      miep_pkg::ST_SQR:   begin mm_a = base;   mm_b = base; end
      miep_pkg::ST_CHECK: begin mm_a = base0;  mm_b = result; end
      default:            begin mm_a = base;   mm_b = base; end
    endcase
  end

  assign mm_start = !launched && (state == miep_pkg::ST_MUL || state == miep_pkg::ST_SQR ||
                                  state == miep_pkg::ST_CHECK);

  miep_mulmod u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mm_start),
    .a     (mm_a),
    .b     (mm_b),
    .m     (m),
    .done  (mm_done),
    .prod  (mm_prod)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= miep_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      miep_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          state_next = (in_ch.modulus < miep_pkg::word_t'(2)) ? miep_pkg::ST_DONE
                                                              : miep_pkg::ST_REDUCE;
        end
      end
      miep_pkg::ST_REDUCE: begin
        if (cnt == miep_pkg::CW'(WIDTH - 1)) begin
          state_next = expo[0] ? miep_pkg::ST_MUL : miep_pkg::ST_SQR;
        end
      end
      miep_pkg::ST_MUL: begin
        if (mm_done) state_next = miep_pkg::ST_SQR;
      end
      miep_pkg::ST_SQR: begin
        if (mm_done) begin
          if (cnt == miep_pkg::CW'(WIDTH - 1)) state_next = miep_pkg::ST_CHECK;
          else if (expo[1]) state_next = miep_pkg::ST_MUL;
        end
      end
      miep_pkg::ST_CHECK: begin
        if (mm_done) state_next = miep_pkg::ST_DONE;
      end
      miep_pkg::ST_DONE: begin
        if (!out_valid || out_ch.ready) state_next = miep_pkg::ST_IDLE;
      end
      default: state_next = miep_pkg::ST_IDLE;
    endcase
  end

  // Launch tracking for the multiplier
  always_ff @(posedge clk) begin
    if (rst) begin
      launched <= 1'b0;
    end else if (mm_done || state_next != state) begin
      launched <= 1'b0;
    end else if (mm_start) begin
      launched <= 1'b1;
    end
  end

  // Datapath registers; modulus below two yields a zero power
  always_ff @(posedge clk) begin
    case (state)
      miep_pkg::ST_IDLE: begin
        m      <= in_ch.modulus;
        quo    <= in_ch.value;
        rem_v  <= '0;
        expo   <= in_ch.totient - miep_pkg::word_t'(1);
        result <= (in_ch.modulus < miep_pkg::word_t'(2)) ? '0 : miep_pkg::word_t'(1);
        cnt    <= '0;
        inv_flag <= 1'b0;
      end
      miep_pkg::ST_REDUCE: begin
        quo <= {quo[WIDTH-2:0], 1'b0};
        if (!rem_try[WIDTH]) rem_v <= rem_try[WIDTH-1:0];
        else                 rem_v <= {rem_v[WIDTH-2:0], quo[WIDTH-1]};
        if (cnt == miep_pkg::CW'(WIDTH - 1)) begin
          cnt   <= '0;
          base  <= (!rem_try[WIDTH]) ? rem_try[WIDTH-1:0]
                                     : {rem_v[WIDTH-2:0], quo[WIDTH-1]};
          base0 <= (!rem_try[WIDTH]) ? rem_try[WIDTH-1:0]
                                     : {rem_v[WIDTH-2:0], quo[WIDTH-1]};
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      miep_pkg::ST_MUL: begin
        if (mm_done) result <= mm_prod;
      end
      miep_pkg::ST_SQR: begin
        if (mm_done) begin
          base <= mm_prod;
          expo <= {1'b0, expo[WIDTH-1:1]};
          cnt  <= cnt + 1'b1;
        end
      end
      miep_pkg::ST_CHECK: begin
        if (mm_done) inv_flag <= (mm_prod == miep_pkg::word_t'(1));
      end
      miep_pkg::ST_DONE: begin
        // Load the result register only once the previous result has left
        if (!out_valid || out_ch.ready) begin
          out_power <= result;
          out_inv   <= inv_flag;
        end
      end
      default: begin
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == miep_pkg::ST_DONE && (!out_valid || out_ch.ready)) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  `MIEP_ASSERT_IMP(a_ready_idle, clk, rst, in_ch.ready, state == miep_pkg::ST_IDLE)
  `MIEP_ASSERT_NEXT(a_start_launch, clk, rst, mm_start, launched || mm_done)
  `MIEP_ASSERT_IMP(a_cnt_range, clk, rst, state == miep_pkg::ST_SQR, cnt < miep_pkg::CW'(WIDTH))
endmodule
